// ===== design/lidar_follow_gap_steering_defines.svh =====
// Assertion macros for the follow-the-gap steering block
`ifndef LIDAR_FOLLOW_GAP_STEERING_DEFINES_SVH
`define LIDAR_FOLLOW_GAP_STEERING_DEFINES_SVH
`ifndef SYNTHESIS
`define LFG_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LFG_ASSERT_ONEHOT(label, clk, rstn, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) $onehot(sig)) else $error(msg);
`else
`define LFG_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define LFG_ASSERT_ONEHOT(label, clk, rstn, sig, msg)
`endif
`endif

// ===== design/lfgs_pkg.sv =====
package lfgs_pkg;
    localparam int RANGE_W = 16;
    localparam int IDX_W   = 11;
    localparam int ANGLE_W = 23;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUBBLE_RAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUBBLE_LIMIT = 3'd5;

    localparam logic [1:0] SPEED_SLOW = 2'd0;
    localparam logic [1:0] SPEED_MED  = 2'd1;
    localparam logic [1:0] SPEED_FAST = 2'd2;

    localparam logic signed [ANGLE_W:0] STEER_ANG_HI = 24'sd4194303;
    localparam logic signed [ANGLE_W:0] STEER_ANG_LO = -24'sd4194304;

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_SMOOTH = 10'b0000000010,
        ST_REACH  = 10'b0000000100,
        ST_DIV    = 10'b0000001000,
        ST_BUBBLE = 10'b0000010000,
        ST_GAP    = 10'b0000100000,
        ST_BEST   = 10'b0001000000,
        ST_ANGLE  = 10'b0010000000,
        ST_SAT    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;
endpackage

// ===== design/lidar_follow_gap_steering.sv =====
// Throughput: one beam word per cycle while loading; no beam is taken until the result
// word leaves. The passes (smooth, bubble, gap search, best search) each walk the beam
// memories one entry per cycle; a 37-step divider sizes the bubble.
// Synchronous active-low reset clears the phase, beam count and valid flags, and loads
// the configuration defaults.
`include "lidar_follow_gap_steering_defines.svh"
module lidar_follow_gap_steering #(
    parameter int MAX_BEAMS = 2048
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [lfgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfgs_pkg::ANGLE_W-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic [lfgs_pkg::RANGE_W-1:0] s_range_mm,
    input  logic s_last_beam,
    output logic m_valid,
    input  logic m_ready,
    output logic [lfgs_pkg::IDX_W-1:0] m_best_index,
    output logic signed [lfgs_pkg::ANGLE_W-1:0] m_steer_ang,
    output logic m_gap_found,
    output logic [lfgs_pkg::IDX_W-1:0] m_gap_first,
    output logic [lfgs_pkg::IDX_W-1:0] m_gap_end,
    output logic [1:0] m_speed_code,
    output logic [lfgs_pkg::RANGE_W-1:0] m_closest_mm,
    output logic [lfgs_pkg::IDX_W-1:0] m_closest_idx
);
    import lfgs_pkg::*;

    localparam int AW = $clog2(MAX_BEAMS);
    localparam int CW = AW + 1;
    localparam int DIV_W = 37;  // radius << 20 fits in 36 bits; quotient width

    // configuration
    logic [15:0] look_ahead_reg, bubble_rad_reg, angle_step_reg, slow_lim_reg, bub_lim_reg;
    logic signed [ANGLE_W-1:0] angle_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            look_ahead_reg  <= 16'd20000;
            bubble_rad_reg  <= 16'd500;
            angle_start_reg <= -23'sd2464154;
            angle_step_reg  <= 16'd4563;
            slow_lim_reg    <= 16'd1000;
            bub_lim_reg     <= 16'd3000;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOOK_AHEAD:   look_ahead_reg  <= cfg_data[15:0];
                REG_BUBBLE_RAD:   bubble_rad_reg  <= cfg_data[15:0];
                REG_ANGLE_START:  angle_start_reg <= cfg_data;
                REG_ANGLE_STEP:   angle_step_reg  <= cfg_data[15:0];
                REG_SLOW_LIMIT:   slow_lim_reg    <= cfg_data[15:0];
                REG_BUBBLE_LIMIT: bub_lim_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // memories: raw beams and the working copy
    logic [15:0] raw_mem  [MAX_BEAMS];
    logic [15:0] work_mem [MAX_BEAMS];
    logic          raw_we, work_we;
    logic [AW-1:0] raw_waddr, raw_raddr, work_waddr, work_raddr;
    logic [15:0]   raw_wdata, work_wdata, raw_rdata, work_rdata;

    always_ff @(posedge aclk) begin
        if (raw_we) raw_mem[raw_waddr] <= raw_wdata;
        raw_rdata <= raw_mem[raw_raddr];
    end
    always_ff @(posedge aclk) begin
        if (work_we) work_mem[work_waddr] <= work_wdata;
        work_rdata <= work_mem[work_raddr];
    end

    state_t state_reg;
    logic [CW-1:0] count_reg;     // beams stored
    logic [CW:0]   ptr_reg;       // pass pointer, one beyond needed range
    logic [CW:0]   lag_reg;       // index of the word now on the read port
    logic          rd_v_reg;      // read port holds a live word
    logic [15:0]   w0_reg, w1_reg; // smoothing window (i-1, i)
    logic [1:0]    win_reg;       // words in the window
    logic [15:0]   closest_reg;
    logic [CW-1:0] cidx_reg;
    logic [15:0]   clip_val;
    logic          rec_reg, found_reg;
    logic [CW-1:0] start_reg, maxw_reg, gfirst_reg, gend_reg, best_reg;
    logic [15:0]   bestv_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [DIV_W-1:0] quo_reg, rem_reg, dvd_reg;
    logic [31:0]   d_reg;
    logic [5:0]    dcnt_reg;
    logic signed [ANGLE_W+13:0] ang_reg;
    logic          out_v_reg;

    assign clip_val = (look_ahead_reg >= 16'd1000) ? look_ahead_reg - 16'd1000 : 16'd0;
    assign s_ready  = (state_reg == ST_LOAD);

    // smoothing arithmetic over the window plus the incoming word
    logic [17:0] sum3;
    logic [35:0] third_prod;
    logic [15:0] avg, clipped;
    logic [CW:0] last_i;
    logic [CW-1:0] work_waddr_full;
    logic [17:0]   sum_sel;
    always_comb begin
        sum3 = 18'(w0_reg) + 18'(w1_reg) + 18'(raw_rdata);
        // divide by three: multiply by ceil(2^19 / 3), drop 19 bits
        third_prod = 36'(sum3) * 36'(18'd174763);
        avg = third_prod[34:19];
    end

    // combinational bits used by the passes
    logic [CW:0] cnt_ext;
    assign cnt_ext = (CW+1)'(count_reg);
    assign last_i  = lag_reg;

    // candidate for the divider subtract
    logic [DIV_W:0] rem_sh;
    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};

    logic [CW+15:0] prod;
    assign prod = best_reg * angle_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            out_v_reg <= 1'b0;
            rd_v_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        if (s_last_beam) begin
                            state_reg <= ST_SMOOTH;
                            ptr_reg   <= '0;
                            rd_v_reg  <= 1'b0;
                            win_reg   <= '0;
                            closest_reg <= look_ahead_reg;
                            cidx_reg  <= '0;
                            if (count_reg < CW'(MAX_BEAMS)) count_reg <= count_reg + 1'b1;
                        end else if (count_reg < CW'(MAX_BEAMS)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                // walk raw_mem; emit smoothed word i when word i+1 (or end) is seen
                ST_SMOOTH: begin
                    rd_v_reg <= (ptr_reg < cnt_ext);
                    lag_reg  <= ptr_reg;
                    ptr_reg  <= ptr_reg + 1'b1;
                    if (rd_v_reg || (lag_reg == cnt_ext && win_reg != 2'd0)) begin
                        w0_reg <= w1_reg;
                        w1_reg <= rd_v_reg ? raw_rdata : 16'd0;
                        win_reg <= (win_reg == 2'd2) ? 2'd2 : win_reg + 1'b1;
                    end
                    if (ptr_reg > cnt_ext + 1'b1) state_reg <= ST_REACH;
                    if (work_we && clipped < closest_reg) begin
                        closest_reg <= clipped;
                        cidx_reg    <= work_waddr_full;
                    end
                end
                ST_REACH: begin
                    d_reg <= 32'(closest_reg) * 32'(angle_step_reg);
                    dvd_reg <= DIV_W'({bubble_rad_reg, 20'd0});
                    rem_reg <= '0;
                    dcnt_reg <= 6'(DIV_W);
                    if (closest_reg < bub_lim_reg) state_reg <= ST_DIV;
                    else begin
                        state_reg <= ST_GAP;
                        ptr_reg <= '0;
                        rd_v_reg <= 1'b0;
                        rec_reg <= 1'b0;
                        found_reg <= 1'b0;
                        maxw_reg <= '0;
                        gfirst_reg <= '0;
                        gend_reg <= '0;
                    end
                end
                // restoring division of (radius << 20) + d - 1 by d, one bit a cycle
                ST_DIV: begin
                    if (dcnt_reg == 6'(DIV_W)) begin
                        dvd_reg <= dvd_reg + DIV_W'(d_reg) - 1'b1;
                        dcnt_reg <= dcnt_reg - 1'b1;
                        quo_reg <= '0;
                    end else if (d_reg == '0) begin
                        lo_reg <= '0;
                        hi_reg <= count_reg - 1'b1;
                        ptr_reg <= '0;
                        state_reg <= ST_BUBBLE;
                    end else if (dcnt_reg != 6'd63) begin
                        if (rem_sh >= (DIV_W+1)'(d_reg)) begin
                            rem_reg <= DIV_W'(rem_sh - (DIV_W+1)'(d_reg));
                            quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= DIV_W'(rem_sh);
                            quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                        end
                        dvd_reg <= dvd_reg << 1;
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end else begin
                        lo_reg <= (DIV_W'(cidx_reg) >= quo_reg) ? CW'(DIV_W'(cidx_reg) - quo_reg)
                                                                : '0;
                        hi_reg <= ((DIV_W'(cidx_reg) + quo_reg) < DIV_W'(count_reg))
                                  ? CW'(DIV_W'(cidx_reg) + quo_reg) : count_reg - 1'b1;
                        state_reg <= ST_BUBBLE;
                    end
                end
                ST_BUBBLE: begin
                    if (lo_reg == hi_reg) begin
                        state_reg <= ST_GAP;
                        ptr_reg <= '0;
                        rd_v_reg <= 1'b0;
                        rec_reg <= 1'b0;
                        found_reg <= 1'b0;
                        maxw_reg <= '0;
                        gfirst_reg <= '0;
                        gend_reg <= '0;
                    end else lo_reg <= lo_reg + 1'b1;
                end
                ST_GAP: begin
                    lag_reg  <= ptr_reg;
                    if (rd_v_reg) begin
                        if (work_rdata != 16'd0 && (last_i + 1'b1) != cnt_ext) begin
                            if (!rec_reg) begin
                                rec_reg <= 1'b1;
                                start_reg <= CW'(last_i);
                            end
                        end else if (rec_reg) begin
                            rec_reg <= 1'b0;
                            if (CW'(last_i) - start_reg > maxw_reg) begin
                                maxw_reg <= CW'(last_i) - start_reg;
                                gfirst_reg <= start_reg;
                                gend_reg <= CW'(last_i);
                                found_reg <= 1'b1;
                            end
                        end
                    end
                    if (ptr_reg > cnt_ext) begin
                        state_reg <= ST_BEST;
                        ptr_reg <= (CW+1)'(gfirst_reg);
                        rd_v_reg <= 1'b0;
                        best_reg <= '0;
                        bestv_reg <= '0;
                    end else begin
                        rd_v_reg <= (ptr_reg < cnt_ext);
                        ptr_reg  <= ptr_reg + 1'b1;
                    end
                end
                ST_BEST: begin
                    rd_v_reg <= found_reg && (ptr_reg < (CW+1)'(gend_reg));
                    lag_reg  <= ptr_reg;
                    ptr_reg  <= ptr_reg + 1'b1;
                    if (rd_v_reg && work_rdata > bestv_reg) begin
                        bestv_reg <= work_rdata;
                        best_reg <= CW'(last_i);
                    end
                    if (!found_reg || ptr_reg > (CW+1)'(gend_reg)) state_reg <= ST_ANGLE;
                end
                ST_ANGLE: begin
                    ang_reg <= 37'(angle_start_reg) + $signed(37'(prod));
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    out_v_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        out_v_reg <= 1'b0;
                        count_reg <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // memory port control
    always_comb begin
        raw_we = 1'b0;
        raw_waddr = count_reg[AW-1:0];
        raw_wdata = s_range_mm;
        raw_raddr = ptr_reg[AW-1:0];
        work_we = 1'b0;
        work_waddr_full = '0;
        work_wdata = '0;
        work_raddr = ptr_reg[AW-1:0];
        sum_sel = '0;
        clipped = '0;
        if (state_reg == ST_LOAD && s_valid && count_reg < CW'(MAX_BEAMS)) raw_we = 1'b1;
        // smoothed word for centre w1 once the next word (or scan end) is known
        if (state_reg == ST_SMOOTH && win_reg != 2'd0
            && (rd_v_reg || lag_reg == cnt_ext)) begin
            work_we = 1'b1;
            work_waddr_full = CW'(lag_reg - 1'b1);
            if (win_reg == 2'd1 && !rd_v_reg) sum_sel = 18'(w1_reg);
            else if (win_reg == 2'd1) sum_sel = 18'((18'(w1_reg) + 18'(raw_rdata)) >> 1);
            else if (!rd_v_reg) sum_sel = 18'((18'(w0_reg) + 18'(w1_reg)) >> 1);
            else sum_sel = 18'(avg);
            clipped = (sum_sel[15:0] > look_ahead_reg) ? clip_val : sum_sel[15:0];
            work_wdata = clipped;
        end
        if (state_reg == ST_BUBBLE) begin
            work_we = 1'b1;
            work_waddr_full = lo_reg;
            work_wdata = '0;
        end
        work_waddr = work_waddr_full[AW-1:0];
    end

    logic signed [ANGLE_W+13:0] ang_sat;
    always_comb begin
        if (ang_reg > 37'(STEER_ANG_HI)) ang_sat = 37'(STEER_ANG_HI);
        else if (ang_reg < 37'(STEER_ANG_LO)) ang_sat = 37'(STEER_ANG_LO);
        else ang_sat = ang_reg;
    end

    assign m_valid          = out_v_reg;
    assign m_best_index     = IDX_W'(best_reg);
    assign m_steer_ang      = ANGLE_W'(ang_sat);
    assign m_gap_found      = found_reg;
    assign m_gap_first      = IDX_W'(gfirst_reg);
    assign m_gap_end        = IDX_W'(gend_reg);
    assign m_speed_code     = (closest_reg < slow_lim_reg) ? SPEED_SLOW :
                              (closest_reg < bub_lim_reg) ? SPEED_MED : SPEED_FAST;
    assign m_closest_mm     = closest_reg;
    assign m_closest_idx    = IDX_W'(cidx_reg);

    `LFG_ASSERT_ONEHOT(a_state_onehot, aclk, aresetn, state_reg, "state not one-hot")
    `LFG_ASSERT_IMPL(a_no_load_busy, aclk, aresetn, m_valid |-> !s_ready, "ready while result held")
    `LFG_ASSERT_IMPL(a_count_cap, aclk, aresetn, count_reg <= CW'(MAX_BEAMS), "beam count overflow")
endmodule
